@@ design/c2p_pkg.sv @@
package c2p_pkg;

    // Fixed-point field widths.
    localparam int WORD_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int HEAT_W    = 19;
    localparam int GAS_W     = 31;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HEAT_RATIO = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAS_CONST  = 1'b1;

    // Square root unit: 64-bit radicand, 32-bit root.
    localparam int SQ_IN_W   = 64;
    localparam int SQRT_LAT  = SQ_IN_W / 2 + 1;

    // Default divider shape: Q16.16 numerator over a positive density.
    localparam int DIV_NUM_W = WORD_W + FRAC_W;
    localparam int DIV_DEN_W = WORD_W - 1;
    localparam int DIV_QUO_W = WORD_W;

    // Latency of the restoring divider for a given quotient width.
    function automatic int div_lat(input int qw);
        return qw + 1;
    endfunction

endpackage

@@ design/euler_conserved_to_primitive.sv @@
// Converts one cell's conserved flow state into primitive quantities, in
// signed Q16.16, speeds in unsigned Q15.16. The block is a fixed pipeline: it
// takes one request in every cycle, busy is always low, and each result
// comes out with o_valid high for one cycle. The receiver cannot stall, so
// results must be taken when they appear. The longest chain runs through the
// kinetic energy divide (49 quotient bits), the multiply by gamma minus one,
// the gamma times pressure over density divide (48 quotient bits) and the
// 32-step square root for the sound speed. Configuration writes are always
// ready and must only be made while no request is in flight.
module euler_conserved_to_primitive
    import c2p_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic signed [31:0]    i_density,
    input  logic signed [31:0]    i_momentum_x,
    input  logic signed [31:0]    i_momentum_y,
    input  logic signed [31:0]    i_total_energy,
    input  logic signed [31:0]    i_turb_energy,
    input  logic signed [31:0]    i_turb_dissipation,
    input  logic signed [31:0]    i_intermittency_mass,
    input  logic signed [31:0]    i_transition_re_mass,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    output logic                  o_valid,
    output logic signed [31:0]    o_velocity_x,
    output logic signed [31:0]    o_velocity_y,
    output logic [30:0]           o_speed,
    output logic signed [31:0]    o_pressure,
    output logic signed [31:0]    o_temperature,
    output logic signed [31:0]    o_enthalpy,
    output logic signed [31:0]    o_specific_energy,
    output logic [30:0]           o_sound_speed,
    output logic signed [31:0]    o_turb_k,
    output logic signed [31:0]    o_turb_omega,
    output logic signed [31:0]    o_intermittency,
    output logic signed [31:0]    o_transition_re
);

    localparam logic [HEAT_W-1:0] HEAT_RESET = 19'd91750;
    localparam logic [GAS_W-1:0]  GAS_RESET  = 31'd18808832;

    localparam logic signed [31:0] MAX_POS = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN_NEG = 32'sh8000_0000;
    localparam logic [30:0]        MAX_U31 = 31'h7FFF_FFFF;

    localparam logic signed [50:0] INNER_LIM = 51'sd140737488355328;
    localparam logic signed [52:0] P_MAX     = 53'sd2147483647;
    localparam logic signed [52:0] P_MIN     = -53'sd2147483648;
    localparam logic signed [19:0] ONE_Q     = 20'sd65536;

    localparam int NLANE  = 7;
    localparam int KE_QW  = 49;
    localparam int ARG_QW = 48;

    // Pipeline stage numbers; stage 1 holds the captured request.
    localparam int S_IN   = 1;
    localparam int S_Q    = S_IN + div_lat(WORD_W);
    localparam int S_QF   = S_Q + 1;
    localparam int S_SQ   = S_QF + 1;
    localparam int S_VV   = S_SQ + 1;
    localparam int S_SPD  = S_VV + SQRT_LAT;
    localparam int S_SPDF = S_SPD + 1;
    localparam int S_MSQ  = S_IN + 1;
    localparam int S_MM   = S_MSQ + 1;
    localparam int S_KE   = S_MM + div_lat(KE_QW);
    localparam int S_INR  = S_KE + 1;
    localparam int S_PRD  = S_INR + 1;
    localparam int S_P    = S_PRD + 1;
    localparam int S_PM   = S_P + 1;
    localparam int S_HM   = S_PM + 1;
    localparam int S_T    = S_PM + div_lat(WORD_W);
    localparam int S_TF   = S_T + 1;
    localparam int S_H    = S_HM + div_lat(WORD_W);
    localparam int S_HF   = S_H + 1;
    localparam int S_A    = S_PM + div_lat(ARG_QW);
    localparam int S_SS   = S_A + SQRT_LAT;
    localparam int S_SSF  = S_SS + 1;
    localparam int S_OUT  = S_SSF + 1;

    // Quotient magnitude with sign applied, saturated to 32 bits.
    function automatic logic signed [31:0] sat_div(input logic [31:0] mag,
                                                   input logic ovf,
                                                   input logic neg);
        logic signed [31:0] res;
        if (neg) begin
            if (ovf || (mag > 32'h8000_0000)) res = MIN_NEG;
            else res = -mag;
        end else begin
            if (ovf || mag[31]) res = MAX_POS;
            else res = mag;
        end
        return res;
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] x);
        return x[31] ? -x : x;
    endfunction

    logic [HEAT_W-1:0] r_heat_ratio;
    logic [GAS_W-1:0]  r_gas_const;
    logic [S_OUT-1:0]  r_vld;
    logic              w_accept;

    // Stage 1: captured request.
    logic signed [31:0] r_in_rho;
    logic               r_in_bad;
    logic [31:0]        r_in_mag [NLANE];
    logic [NLANE-1:0]   r_in_neg;
    logic signed [32:0] r_in_etk;
    logic signed [31:0] r_in_en;
    logic signed [31:0] w_lane_in [NLANE];

    // Per-mass quotients.
    logic [31:0]        w_q    [NLANE];
    logic               w_qovf [NLANE];
    logic [NLANE-1:0]   w_neg_q;
    logic signed [31:0] r_lane [NLANE];
    logic [NLANE*32-1:0] w_lane_pk;
    logic [NLANE*32-1:0] w_lane_out;

    // Speed.
    logic [63:0]        r_u2, r_v2, r_vv;
    logic [31:0]        w_spd;
    logic [30:0]        r_spd;
    logic [30:0]        w_spd_out;

    // Kinetic energy and pressure.
    logic [63:0]        r_mx2, r_my2, r_mm;
    logic [31:0]        w_rho_mm;
    logic [KE_QW-1:0]   w_ke_q;
    logic               w_ke_ovf;
    logic [KE_QW-1:0]   w_ke;
    logic [32:0]        w_etk_ke;
    logic signed [50:0] w_wide;
    logic signed [48:0] r_inner;
    logic signed [19:0] w_gm1;
    logic signed [68:0] r_prod;
    logic signed [52:0] w_pw;
    logic signed [31:0] r_p;
    logic [31:0]        w_rho_prd;
    logic signed [31:0] r_p_rho;
    logic [31:0]        w_en_p;
    logic [31:0]        w_p_out;

    // Temperature, enthalpy, sound speed.
    logic [31:0]        r_pmag;
    logic               r_pneg;
    logic [61:0]        r_rrho;
    logic signed [32:0] r_h;
    logic signed [51:0] r_gp;
    logic signed [31:0] r_pm_rho;
    logic [31:0]        w_t_q;
    logic               w_t_ovf;
    logic               w_pneg_t;
    logic signed [31:0] r_temp;
    logic [31:0]        w_t_out;
    logic [32:0]        r_hmag;
    logic               r_hneg;
    logic [30:0]        r_hm_rho;
    logic [31:0]        w_h_q;
    logic               w_h_ovf;
    logic               w_hneg_h;
    logic signed [31:0] r_enth;
    logic [31:0]        w_h_out;
    logic [ARG_QW-1:0]  w_a_q;
    logic               w_a_ovf;
    logic               w_big;
    logic               w_big_ss;
    logic               w_pneg_ss;
    logic [31:0]        w_ss_root;
    logic [30:0]        r_ss;
    logic               w_bad_out;

    // Output registers.
    logic signed [31:0] r_out_vx, r_out_vy, r_out_p, r_out_t, r_out_h, r_out_e;
    logic signed [31:0] r_out_k, r_out_om, r_out_gt, r_out_re;
    logic [30:0]        r_out_spd, r_out_ss;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start & ~busy;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heat_ratio <= HEAT_RESET;
            r_gas_const  <= GAS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_HEAT_RATIO: r_heat_ratio <= i_cfg_data[HEAT_W-1:0];
                CFG_GAS_CONST:  r_gas_const  <= i_cfg_data[GAS_W-1:0];
            endcase
        end
    end

    // Valid bits follow each request down the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[S_OUT-2:0], w_accept};
        end
    end

    // Stage 1: capture the request and split the divided fields into sign
    // and magnitude.
    assign w_lane_in[0] = i_momentum_x;
    assign w_lane_in[1] = i_momentum_y;
    assign w_lane_in[2] = i_total_energy;
    assign w_lane_in[3] = i_turb_energy;
    assign w_lane_in[4] = i_turb_dissipation;
    assign w_lane_in[5] = i_intermittency_mass;
    assign w_lane_in[6] = i_transition_re_mass;

    always_ff @(posedge i_clk) begin
        r_in_rho <= i_density;
        r_in_bad <= (i_density <= 0);
        r_in_en  <= i_total_energy;
        r_in_etk <= {i_total_energy[31], i_total_energy}
                  - {i_turb_energy[31], i_turb_energy};
        for (int g = 0; g < NLANE; g++) begin
            r_in_mag[g] <= abs32(w_lane_in[g]);
            r_in_neg[g] <= w_lane_in[g][31];
        end
    end

    // Per-mass quotients: each field times 2^16 over density.
    for (genvar g = 0; g < NLANE; g++) begin : g_lane
        c2p_div #(.NW(DIV_NUM_W), .DW(DIV_DEN_W), .QW(WORD_W)) u_div (
            .i_clk (i_clk),
            .i_num ({r_in_mag[g], {FRAC_W{1'b0}}}),
            .i_den (r_in_rho[30:0]),
            .o_quo (w_q[g]),
            .o_ovf (w_qovf[g])
        );
    end

    c2p_dly #(.W(NLANE), .D(S_Q - S_IN)) u_neg_q (
        .i_clk (i_clk), .i_d (r_in_neg), .o_q (w_neg_q)
    );

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < NLANE; g++) begin
            r_lane[g] <= sat_div(w_q[g], w_qovf[g], w_neg_q[g]);
        end
    end

    // Speed from the saturated velocities.
    always_ff @(posedge i_clk) begin
        r_u2 <= r_lane[0] * r_lane[0];
        r_v2 <= r_lane[1] * r_lane[1];
        r_vv <= r_u2 + r_v2;
        r_spd <= w_spd[31] ? MAX_U31 : w_spd[30:0];
    end

    c2p_sqrt #(.IW(SQ_IN_W)) u_sqrt_spd (
        .i_clk (i_clk), .i_val (r_vv), .o_root (w_spd)
    );

    // Kinetic energy: (mx^2 + my^2) / (2 rho).
    always_ff @(posedge i_clk) begin
        r_mx2 <= r_in_mag[0] * r_in_mag[0];
        r_my2 <= r_in_mag[1] * r_in_mag[1];
        r_mm  <= r_mx2 + r_my2;
    end

    c2p_dly #(.W(32), .D(S_MM - S_IN)) u_rho_mm (
        .i_clk (i_clk), .i_d (r_in_rho), .o_q (w_rho_mm)
    );

    c2p_div #(.NW(64), .DW(32), .QW(KE_QW)) u_div_ke (
        .i_clk (i_clk),
        .i_num (r_mm),
        .i_den ({w_rho_mm[30:0], 1'b0}),
        .o_quo (w_ke_q),
        .o_ovf (w_ke_ovf)
    );

    c2p_dly #(.W(33), .D(S_KE - S_IN)) u_etk (
        .i_clk (i_clk), .i_d (r_in_etk), .o_q (w_etk_ke)
    );

    // A kinetic energy past 2^49 already drives the inner term to its clamp.
    assign w_ke   = w_ke_ovf ? {KE_QW{1'b1}} : w_ke_q;
    assign w_wide = $signed({{18{w_etk_ke[32]}}, w_etk_ke}) - $signed({2'b00, w_ke});
    assign w_gm1  = $signed({1'b0, r_heat_ratio}) - ONE_Q;
    assign w_pw   = r_prod[68:16];

    // Pressure: clamp the inner energy, scale by gamma minus one, floor.
    always_ff @(posedge i_clk) begin
        if (w_wide > INNER_LIM) r_inner <= INNER_LIM[48:0];
        else if (w_wide < -INNER_LIM) r_inner <= -INNER_LIM[48:0];
        else r_inner <= w_wide[48:0];

        r_prod <= r_inner * w_gm1;

        if (w_pw > P_MAX) r_p <= MAX_POS;
        else if (w_pw < P_MIN) r_p <= MIN_NEG;
        else r_p <= w_pw[31:0];
    end

    c2p_dly #(.W(32), .D(S_PRD - S_IN)) u_rho_prd (
        .i_clk (i_clk), .i_d (r_in_rho), .o_q (w_rho_prd)
    );

    c2p_dly #(.W(32), .D(S_P - S_IN)) u_en_p (
        .i_clk (i_clk), .i_d (r_in_en), .o_q (w_en_p)
    );

    // Operands of the three pressure-dependent divides.
    always_ff @(posedge i_clk) begin
        r_p_rho  <= w_rho_prd;
        r_pmag   <= abs32(r_p);
        r_pneg   <= r_p[31];
        r_rrho   <= r_gas_const * r_p_rho[30:0];
        r_h      <= {w_en_p[31], w_en_p} + {r_p[31], r_p};
        r_gp     <= $signed({1'b0, r_heat_ratio}) * r_p;
        r_pm_rho <= r_p_rho;
        r_hmag   <= r_h[32] ? -r_h : r_h;
        r_hneg   <= r_h[32];
        r_hm_rho <= r_pm_rho[30:0];
    end

    // Temperature: p * 2^32 / (R rho).
    c2p_div #(.NW(64), .DW(62), .QW(WORD_W)) u_div_t (
        .i_clk (i_clk),
        .i_num ({r_pmag, 32'h0}),
        .i_den (r_rrho),
        .o_quo (w_t_q),
        .o_ovf (w_t_ovf)
    );

    c2p_dly #(.W(1), .D(S_T - S_PM)) u_pneg_t (
        .i_clk (i_clk), .i_d (r_pneg), .o_q (w_pneg_t)
    );

    always_ff @(posedge i_clk) begin
        if (r_gas_const == '0) r_temp <= w_pneg_t ? MIN_NEG : MAX_POS;
        else r_temp <= sat_div(w_t_q, w_t_ovf, w_pneg_t);
    end

    // Enthalpy: (rho E + p) / rho.
    c2p_div #(.NW(49), .DW(31), .QW(WORD_W)) u_div_h (
        .i_clk (i_clk),
        .i_num ({r_hmag, {FRAC_W{1'b0}}}),
        .i_den (r_hm_rho),
        .o_quo (w_h_q),
        .o_ovf (w_h_ovf)
    );

    c2p_dly #(.W(1), .D(S_H - S_HM)) u_hneg (
        .i_clk (i_clk), .i_d (r_hneg), .o_q (w_hneg_h)
    );

    always_ff @(posedge i_clk) begin
        r_enth <= sat_div(w_h_q, w_h_ovf, w_hneg_h);
    end

    // Sound speed: sqrt(gamma p / rho). A negative pressure gives zero, so the
    // quotient only matters for a nonnegative product.
    c2p_div #(.NW(50), .DW(31), .QW(ARG_QW)) u_div_a (
        .i_clk (i_clk),
        .i_num (r_gp[49:0]),
        .i_den (r_pm_rho[30:0]),
        .o_quo (w_a_q),
        .o_ovf (w_a_ovf)
    );

    assign w_big = w_a_ovf | w_a_q[ARG_QW-1];

    c2p_sqrt #(.IW(SQ_IN_W)) u_sqrt_ss (
        .i_clk  (i_clk),
        .i_val  ({1'b0, w_a_q[ARG_QW-2:0], {FRAC_W{1'b0}}}),
        .o_root (w_ss_root)
    );

    c2p_dly #(.W(1), .D(S_SS - S_A)) u_big (
        .i_clk (i_clk), .i_d (w_big), .o_q (w_big_ss)
    );

    c2p_dly #(.W(1), .D(S_SS - S_PM)) u_pneg_ss (
        .i_clk (i_clk), .i_d (r_pneg), .o_q (w_pneg_ss)
    );

    always_ff @(posedge i_clk) begin
        if (w_pneg_ss) r_ss <= '0;
        else if (w_big_ss || w_ss_root[31]) r_ss <= MAX_U31;
        else r_ss <= w_ss_root[30:0];
    end

    // Align every finished value with the sound speed.
    always_comb begin
        for (int g = 0; g < NLANE; g++) begin
            w_lane_pk[g*32 +: 32] = r_lane[g];
        end
    end

    c2p_dly #(.W(NLANE*32), .D(S_SSF - S_QF)) u_lane_out (
        .i_clk (i_clk), .i_d (w_lane_pk), .o_q (w_lane_out)
    );

    c2p_dly #(.W(31), .D(S_SSF - S_SPDF)) u_spd_out (
        .i_clk (i_clk), .i_d (r_spd), .o_q (w_spd_out)
    );

    c2p_dly #(.W(32), .D(S_SSF - S_P)) u_p_out (
        .i_clk (i_clk), .i_d (r_p), .o_q (w_p_out)
    );

    c2p_dly #(.W(32), .D(S_SSF - S_TF)) u_t_out (
        .i_clk (i_clk), .i_d (r_temp), .o_q (w_t_out)
    );

    c2p_dly #(.W(32), .D(S_SSF - S_HF)) u_h_out (
        .i_clk (i_clk), .i_d (r_enth), .o_q (w_h_out)
    );

    c2p_dly #(.W(1), .D(S_SSF - S_IN)) u_bad_out (
        .i_clk (i_clk), .i_d (r_in_bad), .o_q (w_bad_out)
    );

    // Output register; a nonpositive density saturates every field.
    always_ff @(posedge i_clk) begin
        if (w_bad_out) begin
            r_out_vx  <= MAX_POS;
            r_out_vy  <= MAX_POS;
            r_out_spd <= MAX_U31;
            r_out_p   <= MAX_POS;
            r_out_t   <= MAX_POS;
            r_out_h   <= MAX_POS;
            r_out_e   <= MAX_POS;
            r_out_ss  <= MAX_U31;
            r_out_k   <= MAX_POS;
            r_out_om  <= MAX_POS;
            r_out_gt  <= MAX_POS;
            r_out_re  <= MAX_POS;
        end else begin
            r_out_vx  <= w_lane_out[0*32 +: 32];
            r_out_vy  <= w_lane_out[1*32 +: 32];
            r_out_spd <= w_spd_out;
            r_out_p   <= w_p_out;
            r_out_t   <= w_t_out;
            r_out_h   <= w_h_out;
            r_out_e   <= w_lane_out[2*32 +: 32];
            r_out_ss  <= r_ss;
            r_out_k   <= w_lane_out[3*32 +: 32];
            r_out_om  <= w_lane_out[4*32 +: 32];
            r_out_gt  <= w_lane_out[5*32 +: 32];
            r_out_re  <= w_lane_out[6*32 +: 32];
        end
    end

    assign o_valid           = r_vld[S_OUT-1];
    assign o_velocity_x      = r_out_vx;
    assign o_velocity_y      = r_out_vy;
    assign o_speed           = r_out_spd;
    assign o_pressure        = r_out_p;
    assign o_temperature     = r_out_t;
    assign o_enthalpy        = r_out_h;
    assign o_specific_energy = r_out_e;
    assign o_sound_speed     = r_out_ss;
    assign o_turb_k          = r_out_k;
    assign o_turb_omega      = r_out_om;
    assign o_intermittency   = r_out_gt;
    assign o_transition_re   = r_out_re;

`ifndef SYNTHESIS
    // A negative pressure never yields a nonzero sound speed.
    a_ss_neg_p: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pressure[31] |-> o_sound_speed == '0)
        else $error("sound speed nonzero for negative pressure");

    // Temperature keeps the sign of a negative pressure.
    a_temp_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pressure[31] |-> o_temperature[31] || o_temperature == '0)
        else $error("temperature positive for negative pressure");

    // The speed is never below a nonnegative x velocity.
    a_speed_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_velocity_x[31] |-> o_speed >= o_velocity_x[30:0])
        else $error("speed below x velocity");

    // Reset flushes the pipeline.
    a_rst_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");
`endif

endmodule

@@ design/c2p_div.sv @@
module c2p_div
    import c2p_pkg::*;
#(
    parameter int NW = DIV_NUM_W,
    parameter int DW = DIV_DEN_W,
    parameter int QW = DIV_QUO_W
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo,
    output logic          o_ovf
);

    localparam int HW = NW - QW;
    localparam int CW = (HW > DW) ? HW : DW;

    logic [DW-1:0] r_rem [QW+1];
    logic [QW-1:0] r_low [QW+1];
    logic [QW-1:0] r_quo [QW+1];
    logic [DW-1:0] r_den [QW+1];
    logic          r_ovf [QW+1];

    logic [DW:0]   w_try  [QW];
    logic [DW:0]   w_diff [QW];
    logic          w_ge   [QW];

    // One trial subtraction per stage.
    always_comb begin
        for (int s = 0; s < QW; s++) begin
            w_try[s]  = {r_rem[s], r_low[s][QW-1]};
            w_diff[s] = w_try[s] - {1'b0, r_den[s]};
            w_ge[s]   = (w_try[s] >= {1'b0, r_den[s]});
        end
    end

    // The first stage flags a quotient that does not fit in QW bits; the
    // others develop one quotient bit each, most significant first.
    always_ff @(posedge i_clk) begin
        r_ovf[0] <= (CW'(i_num[NW-1:QW]) >= CW'(i_den));
        r_rem[0] <= DW'(i_num[NW-1:QW]);
        r_low[0] <= i_num[QW-1:0];
        r_quo[0] <= '0;
        r_den[0] <= i_den;
        for (int s = 0; s < QW; s++) begin
            r_rem[s+1] <= w_ge[s] ? w_diff[s][DW-1:0] : w_try[s][DW-1:0];
            r_quo[s+1] <= {r_quo[s][QW-2:0], w_ge[s]};
            r_low[s+1] <= {r_low[s][QW-2:0], 1'b0};
            r_den[s+1] <= r_den[s];
            r_ovf[s+1] <= r_ovf[s];
        end
    end

    assign o_quo = r_quo[QW];
    assign o_ovf = r_ovf[QW];

endmodule

@@ design/c2p_sqrt.sv @@
module c2p_sqrt
    import c2p_pkg::*;
#(
    parameter int IW = SQ_IN_W
) (
    input  logic            i_clk,
    input  logic [IW-1:0]   i_val,
    output logic [IW/2-1:0] o_root
);

    localparam int RW = IW / 2;

    logic [RW+1:0] r_rem  [RW+1];
    logic [RW-1:0] r_root [RW+1];
    logic [IW-1:0] r_rad  [RW+1];

    logic [RW+3:0] w_try   [RW];
    logic [RW+3:0] w_trial [RW];
    logic [RW+3:0] w_sub   [RW];
    logic          w_ge    [RW];

    // Digit recurrence: bring down two radicand bits, try root*4+1.
    always_comb begin
        for (int s = 0; s < RW; s++) begin
            w_try[s]   = {r_rem[s], r_rad[s][IW-1:IW-2]};
            w_trial[s] = {2'b00, r_root[s], 2'b01};
            w_sub[s]   = w_try[s] - w_trial[s];
            w_ge[s]    = (w_try[s] >= w_trial[s]);
        end
    end

    // One root bit per stage.
    always_ff @(posedge i_clk) begin
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_rad[0]  <= i_val;
        for (int s = 0; s < RW; s++) begin
            r_rem[s+1]  <= w_ge[s] ? w_sub[s][RW+1:0] : w_try[s][RW+1:0];
            r_root[s+1] <= {r_root[s][RW-2:0], w_ge[s]};
            r_rad[s+1]  <= {r_rad[s][IW-3:0], 2'b00};
        end
    end

    assign o_root = r_root[RW];

endmodule

@@ design/c2p_dly.sv @@
module c2p_dly
    import c2p_pkg::*;
#(
    parameter int W = WORD_W,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_line [D];

    // Plain shift line that keeps side data aligned with the arithmetic.
    always_ff @(posedge i_clk) begin
        r_line[0] <= i_d;
        for (int k = 1; k < D; k++) begin
            r_line[k] <= r_line[k-1];
        end
    end

    assign o_q = r_line[D-1];

endmodule
